[design/irp_pkg.sv]
// ----------------------------------------------------------------------------
// irp_pkg
// Shared types and codes for the idle-retiring resource pool.
// ----------------------------------------------------------------------------
package irp_pkg;

	localparam int KEY_W   = 64;
	localparam int STAMP_W = 32;
	localparam int IDLE_W  = 17;
	localparam int THR_W   = 16;

	localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

	typedef enum logic [1:0] {
		MODE_ACQUIRE = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_TICK    = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_REUSED   = 3'd0,
		ST_NEW      = 3'd1,
		ST_FULL     = 3'd2,
		ST_DONE     = 3'd3,
		ST_BAD_REL  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACQ_SCAN,
		S_ACQ_APPLY,
		S_TICK_SCAN,
		S_FINISH
	} state_t;

	// write request into the slot memory
	typedef struct packed {
		logic                 key_stamp_en;
		logic                 idle_en;
		logic [KEY_W-1:0]     key;
		logic [STAMP_W-1:0]   stamp;
		logic [IDLE_W-1:0]    idle;
	} slot_wr_t;

endpackage

[design/irp_slot_mem.sv]
// ----------------------------------------------------------------------------
// irp_slot_mem
// Per-slot key, stamp and idle storage: one write port, one registered read.
// ----------------------------------------------------------------------------
module irp_slot_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                         clk,
	input  logic [AW-1:0]                wr_addr,
	input  irp_pkg::slot_wr_t            wr,
	input  logic [AW-1:0]                rd_addr,
	output logic [irp_pkg::KEY_W-1:0]    rd_key,
	output logic [irp_pkg::STAMP_W-1:0]  rd_stamp,
	output logic [irp_pkg::IDLE_W-1:0]   rd_idle
);

	logic [irp_pkg::KEY_W-1:0]   key_mem   [DEPTH];
	logic [irp_pkg::STAMP_W-1:0] stamp_mem [DEPTH];
	logic [irp_pkg::IDLE_W-1:0]  idle_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.key_stamp_en) begin
			key_mem[wr_addr]   <= wr.key;
			stamp_mem[wr_addr] <= wr.stamp;
		end
		if (wr.idle_en) begin
			idle_mem[wr_addr] <= wr.idle;
		end
	end

	always_ff @(posedge clk) begin
		rd_key   <= key_mem[rd_addr];
		rd_stamp <= stamp_mem[rd_addr];
		rd_idle  <= idle_mem[rd_addr];
	end

endmodule

[design/idle_retiring_resource_pool.sv]
// ----------------------------------------------------------------------------
// idle_retiring_resource_pool
// Keyed resource pool with oldest-first reuse and idle-timeout retirement.
// ----------------------------------------------------------------------------
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | mode[1:0] desc_key[65:2] release_index[70:66], pad to 72
//  m_axis   | out | status[2:0] entry_index[7:3] entry_count[13:8]
//           |     | available_count[19:14], pad to 24
//  cfg      | in  | cfg_wen, cfg_wdata = retire_threshold
//
// Acquire and tick sweep the slot memory one slot per cycle through its single
// read port, and acquire then applies its choice in an apply state. Release and
// clear skip the sweep. Every mode ends in a finish state that registers the
// result once m_axis is free. s_axis_tready is low from the transfer until the
// result is registered. A result waiting on m_axis does not block the next
// transfer, only the next result. No clearing pass after reset.
// ----------------------------------------------------------------------------
module idle_retiring_resource_pool #(
	parameter int POOL_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // mode, desc_key, release_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // status, entry_index, entry_count, available_count
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata
);

	localparam int AW = $clog2(POOL_ENTRIES);
	localparam int CW = $clog2(POOL_ENTRIES + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(POOL_ENTRIES - 1);

	irp_pkg::state_t state_q, state_d;

	logic [POOL_ENTRIES-1:0] valid_q, busy_q;
	logic [CW-1:0]           entry_cnt_q, avail_cnt_q;
	logic [irp_pkg::STAMP_W-1:0] next_stamp_q;
	logic [irp_pkg::THR_W-1:0]   thr_q;

	logic          iss_q;
	logic [AW-1:0] scan_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;

	logic [irp_pkg::KEY_W-1:0]   key_q;
	logic                        best_fnd_q, empty_fnd_q;
	logic [AW-1:0]               best_idx_q, empty_idx_q;
	logic [irp_pkg::STAMP_W-1:0] best_age_q;

	irp_pkg::status_t res_status_q;
	logic [4:0]       res_index_q;
	logic             m_valid_q;
	logic [23:0]      m_data_q;

	logic [irp_pkg::KEY_W-1:0]   rd_key;
	logic [irp_pkg::STAMP_W-1:0] rd_stamp;
	logic [irp_pkg::IDLE_W-1:0]  rd_idle;

	irp_pkg::slot_wr_t wr;
	logic [AW-1:0]     wr_addr;

	logic             in_acc;
	irp_pkg::mode_t   in_mode;
	logic [AW-1:0]    rel_idx;
	logic             rel_ok;
	logic             out_free;
	logic             scan_last;
	logic             sv, sb;
	logic [irp_pkg::STAMP_W-1:0] age;
	logic [irp_pkg::IDLE_W-1:0]  idle_inc;
	logic             hit, retire;

	assign in_acc    = s_axis_tvalid & s_axis_tready;
	assign in_mode   = irp_pkg::mode_t'(s_axis_tdata[1:0]);
	assign rel_idx   = AW'(s_axis_tdata[70:66]);
	assign rel_ok    = (int'(s_axis_tdata[70:66]) < POOL_ENTRIES)
		&& valid_q[rel_idx] && busy_q[rel_idx];
	assign out_free  = !m_valid_q || m_axis_tready;
	assign scan_last = vld_s1 && (idx_s1 == LAST_IDX);

	assign sv       = valid_q[idx_s1];
	assign sb       = busy_q[idx_s1];
	assign age      = next_stamp_q - rd_stamp;
	assign hit      = sv && !sb && (rd_key == key_q) && (!best_fnd_q || age > best_age_q);
	assign idle_inc = (rd_idle == irp_pkg::IDLE_MAX) ? rd_idle : rd_idle + 1'b1;
	assign retire   = sv && !sb
		&& (idle_inc > {{(irp_pkg::IDLE_W - irp_pkg::THR_W){1'b0}}, thr_q});

	assign s_axis_tready = (state_q == irp_pkg::S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	irp_slot_mem #(
		.DEPTH (POOL_ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk      (clk),
		.wr_addr  (wr_addr),
		.wr       (wr),
		.rd_addr  (scan_q),
		.rd_key   (rd_key),
		.rd_stamp (rd_stamp),
		.rd_idle  (rd_idle)
	);

	always_comb begin
		state_d = state_q;
		wr      = '0;
		wr_addr = idx_s1;
		unique case (state_q)
			irp_pkg::S_IDLE: begin
				if (in_acc) begin
					unique case (in_mode)
						irp_pkg::MODE_ACQUIRE: state_d = irp_pkg::S_ACQ_SCAN;
						irp_pkg::MODE_TICK:    state_d = irp_pkg::S_TICK_SCAN;
						default:               state_d = irp_pkg::S_FINISH;
					endcase
				end
			end
			irp_pkg::S_ACQ_SCAN: begin
				if (scan_last) state_d = irp_pkg::S_ACQ_APPLY;
			end
			irp_pkg::S_ACQ_APPLY: begin
				wr_addr         = best_fnd_q ? best_idx_q : empty_idx_q;
				wr.idle_en      = best_fnd_q || empty_fnd_q;
				wr.key_stamp_en = !best_fnd_q && empty_fnd_q;
				wr.key          = key_q;
				wr.stamp        = next_stamp_q;
				state_d         = irp_pkg::S_FINISH;
			end
			irp_pkg::S_TICK_SCAN: begin
				wr.idle_en = vld_s1 && sv;
				wr.idle    = sb ? '0 : idle_inc;
				if (scan_last) state_d = irp_pkg::S_FINISH;
			end
			irp_pkg::S_FINISH: begin
				if (out_free) state_d = irp_pkg::S_IDLE;
			end
			default: state_d = irp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			busy_q       <= '0;
			entry_cnt_q  <= '0;
			avail_cnt_q  <= '0;
			next_stamp_q <= '0;
			thr_q        <= '0;
			iss_q        <= 1'b0;
			scan_q       <= '0;
			vld_s1       <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_wen) thr_q <= cfg_wdata;

			vld_s1 <= iss_q;
			if (iss_q) begin
				if (scan_q == LAST_IDX) begin
					iss_q <= 1'b0;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end

			if (in_acc) begin
				unique case (in_mode)
					irp_pkg::MODE_ACQUIRE, irp_pkg::MODE_TICK: begin
						iss_q  <= 1'b1;
						scan_q <= '0;
					end
					irp_pkg::MODE_RELEASE: begin
						if (rel_ok) begin
							busy_q[rel_idx] <= 1'b0;
							avail_cnt_q     <= avail_cnt_q + 1'b1;
						end
					end
					irp_pkg::MODE_CLEAR: begin
						valid_q     <= '0;
						busy_q      <= '0;
						entry_cnt_q <= '0;
						avail_cnt_q <= '0;
					end
					default: ;
				endcase
			end

			if (state_q == irp_pkg::S_ACQ_APPLY) begin
				if (best_fnd_q) begin
					busy_q[best_idx_q] <= 1'b1;
					avail_cnt_q        <= avail_cnt_q - 1'b1;
				end else if (empty_fnd_q) begin
					valid_q[empty_idx_q] <= 1'b1;
					busy_q[empty_idx_q]  <= 1'b1;
					entry_cnt_q          <= entry_cnt_q + 1'b1;
					next_stamp_q         <= next_stamp_q + 1'b1;
				end
			end

			if (state_q == irp_pkg::S_TICK_SCAN && vld_s1 && retire) begin
				valid_q[idx_s1] <= 1'b0;
				entry_cnt_q     <= entry_cnt_q - 1'b1;
				avail_cnt_q     <= avail_cnt_q - 1'b1;
			end

			if (state_q == irp_pkg::S_FINISH && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;

		if (in_acc) begin
			key_q       <= s_axis_tdata[65:2];
			best_fnd_q  <= 1'b0;
			empty_fnd_q <= 1'b0;
			res_index_q <= '0;
			if (in_mode == irp_pkg::MODE_RELEASE && !rel_ok) begin
				res_status_q <= irp_pkg::ST_BAD_REL;
			end else begin
				res_status_q <= irp_pkg::ST_DONE;
			end
		end

		if (state_q == irp_pkg::S_ACQ_SCAN && vld_s1) begin
			if (hit) begin
				best_fnd_q <= 1'b1;
				best_idx_q <= idx_s1;
				best_age_q <= age;
			end
			if (!sv && !empty_fnd_q) begin
				empty_fnd_q <= 1'b1;
				empty_idx_q <= idx_s1;
			end
		end

		if (state_q == irp_pkg::S_ACQ_APPLY) begin
			priority if (best_fnd_q) begin
				res_status_q <= irp_pkg::ST_REUSED;
				res_index_q  <= 5'(best_idx_q);
			end else if (empty_fnd_q) begin
				res_status_q <= irp_pkg::ST_NEW;
				res_index_q  <= 5'(empty_idx_q);
			end else begin
				res_status_q <= irp_pkg::ST_FULL;
				res_index_q  <= '0;
			end
		end

		if (state_q == irp_pkg::S_FINISH && out_free) begin
			m_data_q <= {4'd0, 6'(avail_cnt_q), 6'(entry_cnt_q), res_index_q, res_status_q};
		end
	end

`ifndef NO_ASSERTIONS
	a_avail_le_entry: assert property (@(posedge clk) disable iff (!arst_n)
		avail_cnt_q <= entry_cnt_q)
		else $error("available count above entry count");

	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(entry_cnt_q) <= POOL_ENTRIES)
		else $error("entry count above pool size");

	a_scan_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == irp_pkg::S_ACQ_SCAN || state_q == irp_pkg::S_TICK_SCAN))
		else $error("slot read outside a sweep");

	a_acq_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_mode == irp_pkg::MODE_ACQUIRE) |=> state_q == irp_pkg::S_ACQ_SCAN)
		else $error("acquire did not start a sweep");
`endif

endmodule

[tb/idle_retiring_resource_pool_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_retiring_resource_pool_tb
// Self-checking bench for the keyed resource pool. A queue of requests feeds
// a stream driver; every accepted request runs through a local pool model
// and the expected response is compared against each m_axis transfer. Runs
// a short directed sequence, then random phases at several retire
// thresholds with varying backpressure on both sides.
// ----------------------------------------------------------------------------
module idle_retiring_resource_pool_tb;

	localparam int POOL_N      = 32;
	localparam int KEY_SET_N   = 6;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [4:0]                release_index;
		logic [irp_pkg::KEY_W-1:0] desc_key;
		irp_pkg::mode_t            mode;
	} pool_req_t;

	typedef struct packed {
		logic [5:0]       available_count;
		logic [5:0]       entry_count;
		logic [4:0]       entry_index;
		irp_pkg::status_t status;
	} pool_resp_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;   // mode, desc_key, release_index
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // status, entry_index, entry_count, available_count
	logic        cfg_wen;
	logic [15:0] cfg_wdata;

	// pool model
	logic                         ent_valid [POOL_N] = '{default: 1'b0};
	logic                         ent_busy  [POOL_N] = '{default: 1'b0};
	logic [irp_pkg::KEY_W-1:0]    ent_key   [POOL_N] = '{default: '0};
	logic [irp_pkg::IDLE_W-1:0]   ent_idle  [POOL_N] = '{default: '0};
	logic [irp_pkg::STAMP_W-1:0]  ent_stamp [POOL_N] = '{default: '0};
	logic [irp_pkg::STAMP_W-1:0]  stamp_ctr = '0;
	logic [irp_pkg::THR_W-1:0]    retire_limit;

	pool_req_t   req_q[$];
	pool_resp_t  resp_q[$];
	pool_req_t   req_live;
	pool_resp_t  want, got;
	logic [irp_pkg::KEY_W-1:0] key_set [KEY_SET_N];

	int send_idle_pct;
	int recv_stall_pct;
	int errors = 0;
	int cycle_cnt = 0;
	int n_xfers = 0, n_new = 0, n_reused = 0, n_full = 0, n_bad_rel = 0;
	int n_ticks = 0, n_retired = 0, n_clears = 0;
	int n_settings = 0;

	idle_retiring_resource_pool #(
		.POOL_ENTRIES(POOL_N)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic pool_resp_t pool_apply(pool_req_t req);
		pool_resp_t                  r;
		int                          hit;
		int                          vacant;
		logic [irp_pkg::STAMP_W-1:0] hit_age;
		logic [irp_pkg::STAMP_W-1:0] age;
		r.status      = irp_pkg::ST_DONE;
		r.entry_index = '0;
		hit           = -1;
		vacant        = -1;
		hit_age       = '0;
		n_xfers++;
		case (req.mode)
			irp_pkg::MODE_ACQUIRE: begin
				for (int i = 0; i < POOL_N; i++) begin
					if (ent_valid[i]) begin
						if (!ent_busy[i] && ent_key[i] == req.desc_key) begin
							age = stamp_ctr - ent_stamp[i];
							if (hit < 0 || age > hit_age) begin
								hit     = i;
								hit_age = age;
							end
						end
					end else if (vacant < 0) begin
						vacant = i;
					end
				end
				if (hit >= 0) begin
					ent_busy[hit] = 1'b1;
					ent_idle[hit] = '0;
					r.status      = irp_pkg::ST_REUSED;
					r.entry_index = hit[4:0];
					n_reused++;
				end else if (vacant >= 0) begin
					ent_valid[vacant] = 1'b1;
					ent_busy[vacant]  = 1'b1;
					ent_key[vacant]   = req.desc_key;
					ent_idle[vacant]  = '0;
					ent_stamp[vacant] = stamp_ctr;
					stamp_ctr         = stamp_ctr + 1'b1;
					r.status          = irp_pkg::ST_NEW;
					r.entry_index     = vacant[4:0];
					n_new++;
				end else begin
					r.status = irp_pkg::ST_FULL;
					n_full++;
				end
			end
			irp_pkg::MODE_RELEASE: begin
				if (ent_valid[req.release_index] && ent_busy[req.release_index]) begin
					ent_busy[req.release_index] = 1'b0;
				end else begin
					r.status = irp_pkg::ST_BAD_REL;
					n_bad_rel++;
				end
			end
			irp_pkg::MODE_TICK: begin
				n_ticks++;
				for (int i = 0; i < POOL_N; i++) begin
					if (ent_valid[i]) begin
						if (ent_busy[i]) begin
							ent_idle[i] = '0;
						end else begin
							if (ent_idle[i] < irp_pkg::IDLE_MAX)
								ent_idle[i] = ent_idle[i] + 1'b1;
							if (ent_idle[i] > {1'b0, retire_limit}) begin
								ent_valid[i] = 1'b0;
								ent_busy[i]  = 1'b0;
								n_retired++;
							end
						end
					end
				end
			end
			default: begin
				n_clears++;
				for (int i = 0; i < POOL_N; i++) begin
					ent_valid[i] = 1'b0;
					ent_busy[i]  = 1'b0;
				end
			end
		endcase
		r.entry_count     = '0;
		r.available_count = '0;
		for (int i = 0; i < POOL_N; i++) begin
			if (ent_valid[i]) begin
				r.entry_count = r.entry_count + 1'b1;
				if (!ent_busy[i])
					r.available_count = r.available_count + 1'b1;
			end
		end
		return r;
	endfunction

	function automatic void push_req(irp_pkg::mode_t mode, logic [irp_pkg::KEY_W-1:0] key,
		logic [4:0] idx);
		pool_req_t req;
		req.mode          = mode;
		req.desc_key      = key;
		req.release_index = idx;
		req_q.insert(req_q.size(), req);
	endfunction

	function automatic pool_req_t rand_req();
		pool_req_t req;
		int        pick;
		req.desc_key      = {$urandom, $urandom};
		req.release_index = 5'($urandom_range((1 << $urandom_range(2, 5)) - 1));
		pick              = $urandom_range(99);
		if (pick < 42) begin
			req.mode = irp_pkg::MODE_ACQUIRE;
			if ($urandom_range(9) < 8)
				req.desc_key = key_set[$urandom_range(KEY_SET_N - 1)];
		end else if (pick < 75) begin
			req.mode = irp_pkg::MODE_RELEASE;
		end else if (pick < 97) begin
			req.mode = irp_pkg::MODE_TICK;
		end else begin
			req.mode = irp_pkg::MODE_CLEAR;
		end
		return req;
	endfunction

	task automatic flag_error(string what, pool_resp_t exp_r, pool_resp_t act_r);
		errors++;
		if (errors <= 10) begin
			$display("[%0t] %s: expected st=%0d idx=%0d cnt=%0d avail=%0d",
				$realtime, what, exp_r.status, exp_r.entry_index, exp_r.entry_count,
				exp_r.available_count);
			$display("[%0t] %s: got      st=%0d idx=%0d cnt=%0d avail=%0d",
				$realtime, what, act_r.status, act_r.entry_index, act_r.entry_count,
				act_r.available_count);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (req_q.size() != 0 || s_axis_tvalid || resp_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_threshold(logic [irp_pkg::THR_W-1:0] thr);
		wait_drained();
		@(posedge clk);
		cfg_wen      <= 1'b1;
		cfg_wdata    <= thr;
		retire_limit  = thr;
		@(posedge clk);
		cfg_wen <= 1'b0;
		n_settings++;
	endtask

	task automatic run_phase(logic [irp_pkg::THR_W-1:0] thr, int send_pct, int recv_pct,
		int n_items, bit fill_first);
		set_threshold(thr);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int k = 0; k < KEY_SET_N; k++)
			key_set[k] = {$urandom, $urandom};
		if (fill_first) begin
			// one past capacity so the last acquire hits a full pool
			for (int k = 0; k <= POOL_N; k++)
				push_req(irp_pkg::MODE_ACQUIRE, {$urandom, $urandom}, 5'($urandom));
		end
		for (int k = 0; k < n_items; k++)
			req_q.insert(req_q.size(), rand_req());
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				resp_q.insert(resp_q.size(), pool_apply(req_live));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_live       = req_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {1'b0, req_live};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = pool_resp_t'(m_axis_tdata[19:0]);
				if (resp_q.size() == 0) begin
					flag_error("unexpected response", '0, got);
				end else begin
					want = resp_q.pop_front();
					if (got.status !== want.status || got.entry_index !== want.entry_index ||
						got.entry_count !== want.entry_count ||
						got.available_count !== want.available_count)
						flag_error("response mismatch", want, got);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("idle_retiring_resource_pool_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_wen        = 1'b0;
		cfg_wdata      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		retire_limit   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pool, reuse order, retirement at zero threshold, clear
		set_threshold(16'd0);
		@(negedge clk);
		push_req(irp_pkg::MODE_RELEASE, '0, 5'd0);
		push_req(irp_pkg::MODE_TICK,    '0, 5'd0);
		push_req(irp_pkg::MODE_ACQUIRE, '0, 5'd0);
		push_req(irp_pkg::MODE_ACQUIRE, '1, 5'd31);
		push_req(irp_pkg::MODE_ACQUIRE, '0, 5'd0);
		push_req(irp_pkg::MODE_RELEASE, '0, 5'd0);
		push_req(irp_pkg::MODE_RELEASE, '1, 5'd0);
		push_req(irp_pkg::MODE_RELEASE, '0, 5'd2);
		push_req(irp_pkg::MODE_ACQUIRE, '0, 5'd0);
		push_req(irp_pkg::MODE_ACQUIRE, '1, 5'd0);
		push_req(irp_pkg::MODE_RELEASE, '0, 5'd3);
		push_req(irp_pkg::MODE_TICK,    '1, 5'd31);
		push_req(irp_pkg::MODE_RELEASE, '0, 5'd31);
		push_req(irp_pkg::MODE_ACQUIRE, 64'h8000_0000_0000_0001, 5'd31);
		push_req(irp_pkg::MODE_CLEAR,   '0, 5'd0);
		push_req(irp_pkg::MODE_ACQUIRE, '1, 5'd0);
		push_req(irp_pkg::MODE_RELEASE, '1, 5'd0);
		push_req(irp_pkg::MODE_CLEAR,   '1, 5'd31);

		run_phase(16'hFFFF, 0, 0, 200, 1'b1);
		run_phase(16'd3, 49, 0, 200, 1'b0);
		run_phase(16'd0, 0, 49, 200, 1'b0);
		run_phase(16'($urandom_range(1, 6)), 14, 14, 250, 1'b1);
		run_phase(16'($urandom_range(16'hFFFF)), 0, 0, 100, 1'b0);
		run_phase(16'd1, 14, 14, 150, 1'b0);

		wait_drained();
		repeat (2 * POOL_N) @(posedge clk);
		if (resp_q.size() != 0)
			$display("%0d expected responses never arrived", resp_q.size());

		$display("covered %0d transfers over %0d threshold settings:", n_xfers, n_settings);
		$display("%0d new, %0d reused, %0d full, %0d bad releases, %0d ticks retired %0d, %0d clears",
			n_new, n_reused, n_full, n_bad_rel, n_ticks, n_retired, n_clears);
		if (errors == 0 && resp_q.size() == 0)
			$display("idle_retiring_resource_pool_tb: PASS");
		else
			$display("idle_retiring_resource_pool_tb: FAIL");
		$finish;
	end

endmodule
